FILE: rtl/core/tlnef_pkg.sv
`timescale 1ns / 1ps
package tlnef_pkg;

  localparam int unsigned MODE_W = 6;

  // Bit positions in mode_flags.
  localparam int unsigned MODE_NUM_NONBLANK = 0;
  localparam int unsigned MODE_NUM_ALL      = 1;
  localparam int unsigned MODE_SHOW_ENDS    = 2;
  localparam int unsigned MODE_NONPRINT     = 3;
  localparam int unsigned MODE_TABS         = 4;
  localparam int unsigned MODE_SQUEEZE      = 5;

  // Register indexes.
  localparam logic REG_MODE_FLAGS = 1'b0;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_HIGH   = 8'h80;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // Work handed from the front to the back: an optional line number and
  // one to three trailing bytes, tail[0] going out first.
  typedef struct packed {
    logic            has_num;
    logic [1:0]      tail_len;
    logic [2:0][7:0] tail;
  } job_t;

endpackage

FILE: rtl/core/tlnef_front.sv
`timescale 1ns / 1ps
module tlnef_front #(
  parameter int LINE_DIGITS = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [tlnef_pkg::MODE_W-1:0] mode_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  tlnef_pkg::in_item_t        in_i,
  input  logic                       queue_full_i,
  output logic                       push_o,
  output tlnef_pkg::job_t            job_o,
  output logic [4*LINE_DIGITS-1:0]   bcd_o
);
  import tlnef_pkg::*;

  localparam int BCD_W = 4 * LINE_DIGITS;
  localparam logic [BCD_W-1:0] BCD_ONE = BCD_W'(1);

  logic [BCD_W-1:0] count_q, count_d, eff_count, inc_count;
  logic             start_q, start_d, eff_start;
  logic [1:0]       blank_q, blank_d, eff_blank;
  logic             xfer, is_lf, squeezed, do_num, is_ctrl, use_caret;
  logic [7:0]       c;
  job_t             job;

  assign c          = in_i.in_byte;
  assign in_ready_o = !queue_full_i;
  assign xfer       = in_valid_i && in_ready_o;

  assign eff_count = in_i.start_of_file ? BCD_ONE : count_q;
  assign eff_start = in_i.start_of_file ? 1'b1 : start_q;
  assign eff_blank = in_i.start_of_file ? 2'd0 : blank_q;

  // A digit steps when all digits below it are nine; all nines holds.
  always_comb begin
    logic low_nines;
    low_nines = 1'b1;
    inc_count = eff_count;
    for (int i = 0; i < LINE_DIGITS; i++) begin
      if (low_nines) begin
        inc_count[4*i +: 4] = (eff_count[4*i +: 4] == 4'd9) ? 4'd0
                                                            : eff_count[4*i +: 4] + 4'd1;
      end
      low_nines = low_nines && (eff_count[4*i +: 4] == 4'd9);
    end
    if (low_nines) begin
      inc_count = eff_count;
    end
  end

  assign is_lf     = (c == CH_LF);
  assign is_ctrl   = (c < CH_SPACE) || (c >= CH_DEL);
  assign use_caret = is_ctrl && (mode_i[MODE_NONPRINT] || ((c == CH_TAB) && mode_i[MODE_TABS]));

  always_comb begin
    squeezed = 1'b0;
    do_num   = 1'b0;
    blank_d  = eff_blank;
    start_d  = eff_start;
    job      = '0;
    if (is_lf) begin
      if (eff_start) begin
        blank_d  = (eff_blank == 2'd2) ? 2'd2 : eff_blank + 2'd1;
        squeezed = mode_i[MODE_SQUEEZE] && (blank_d == 2'd2);
        do_num   = !squeezed && mode_i[MODE_NUM_ALL];
      end
      start_d = 1'b1;
      if (mode_i[MODE_SHOW_ENDS]) begin
        job.tail_len = 2'd2;
        job.tail[0]  = CH_DOLLAR;
        job.tail[1]  = CH_LF;
      end else begin
        job.tail_len = 2'd1;
        job.tail[0]  = CH_LF;
      end
    end else begin
      do_num  = eff_start && (mode_i[MODE_NUM_NONBLANK] || mode_i[MODE_NUM_ALL]);
      blank_d = 2'd0;
      start_d = 1'b0;
      if (!use_caret) begin
        job.tail_len = 2'd1;
        job.tail[0]  = c;
      end else if (c >= CH_HIGH) begin
        job.tail_len = 2'd3;
        job.tail[0]  = CH_CARET;
        job.tail[1]  = CH_LBRACK;
        job.tail[2]  = c - CH_HIGH;
      end else if (c == CH_DEL) begin
        job.tail_len = 2'd2;
        job.tail[0]  = CH_CARET;
        job.tail[1]  = CH_QUEST;
      end else begin
        job.tail_len = 2'd2;
        job.tail[0]  = CH_CARET;
        job.tail[1]  = c + CH_AT;
      end
    end
    job.has_num = do_num;
    count_d     = do_num ? inc_count : eff_count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= BCD_ONE;
      start_q <= 1'b1;
      blank_q <= 2'd0;
    end else if (xfer) begin
      count_q <= count_d;
      start_q <= start_d;
      blank_q <= blank_d;
    end
  end

  // A squeezed blank line is taken but leaves nothing to emit.
  assign push_o = xfer && !squeezed;
  assign job_o  = job;
  assign bcd_o  = eff_count;

endmodule

FILE: rtl/core/tlnef_fifo.sv
`timescale 1ns / 1ps
module tlnef_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/tlnef_back.sv
`timescale 1ns / 1ps
module tlnef_back #(
  parameter int LINE_DIGITS = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     job_valid_i,
  input  tlnef_pkg::job_t          job_i,
  input  logic [4*LINE_DIGITS-1:0] bcd_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output tlnef_pkg::out_item_t     out_o
);
  import tlnef_pkg::*;

  localparam int BCD_W = 4 * LINE_DIGITS;
  localparam int NL_W  = $clog2(LINE_DIGITS + 2);

  logic             cur_valid_q;
  logic [NL_W-1:0]  num_left_q;
  logic [BCD_W-1:0] bcd_q;
  logic             seen_q;
  logic [2:0][7:0]  tail_q;
  logic [1:0]       tail_left_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic       out_free, step, last, pop;
  logic [3:0] digit;
  logic [7:0] cur_byte;

  assign out_free = !out_valid_q || out_ready_i;
  assign step     = cur_valid_q && out_free;
  assign digit    = bcd_q[BCD_W-1 -: 4];
  assign last     = (num_left_q == '0) && (tail_left_q == 2'd1);
  assign pop      = job_valid_i && (!cur_valid_q || (step && last));

  // Number digits go out from the top; zeros above the first nonzero digit
  // print as spaces, except the units digit.
  always_comb begin
    if (num_left_q > NL_W'(1)) begin
      if ((digit == 4'd0) && !seen_q && (num_left_q != NL_W'(2))) begin
        cur_byte = CH_SPACE;
      end else begin
        cur_byte = CH_ZERO + {4'd0, digit};
      end
    end else if (num_left_q == NL_W'(1)) begin
      cur_byte = CH_TAB;
    end else begin
      cur_byte = tail_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      num_left_q  <= '0;
      tail_left_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop) begin
        cur_valid_q <= 1'b1;
        num_left_q  <= job_i.has_num ? NL_W'(LINE_DIGITS + 1) : '0;
        tail_left_q <= job_i.tail_len;
      end else if (step) begin
        if (last) begin
          cur_valid_q <= 1'b0;
        end
        if (num_left_q != '0) begin
          num_left_q <= num_left_q - 1'b1;
        end else begin
          tail_left_q <= tail_left_q - 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q.out_byte    <= cur_byte;
      out_q.last_of_run <= last;
    end
    if (pop) begin
      bcd_q  <= bcd_i;
      seen_q <= 1'b0;
      tail_q <= job_i.tail;
    end else if (step) begin
      if (num_left_q > NL_W'(1)) begin
        bcd_q  <= bcd_q << 4;
        seen_q <= seen_q || (digit != 4'd0);
      end else if (num_left_q == '0) begin
        tail_q <= {8'h00, tail_q[2:1]};
      end
    end
  end

  assign pop_o       = pop;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: rtl/core/text_line_number_escape_filter_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// in        input      in_valid_i/in_ready_o   in_i (in_byte, start_of_file)
// out       output     out_valid_o/out_ready_i out_o (out_byte, last_of_run)
// cfg       input      APB psel/penable/pwrite mode_flags at byte address 0
//
// The emitter sends the bytes of an item one at a time and stalls while the
// output is held; a plain byte yields one, any item up to LINE_DIGITS + 4.
// With the queue and emitter idle, an input byte passes through the queue,
// the job register and the output register before its first byte is valid.
// Reset clears the line count to one, line start to one and the blank run.
// The front stalls input only when the two-entry job queue is full.
module text_line_number_escape_filter_top #(
  parameter int LINE_DIGITS = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tlnef_pkg::in_item_t  in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tlnef_pkg::out_item_t out_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import tlnef_pkg::*;

  localparam int BCD_W   = 4 * LINE_DIGITS;
  localparam int JOB_W   = $bits(job_t);
  localparam int ENTRY_W = JOB_W + BCD_W;

  logic [MODE_W-1:0]  mode_q;
  logic               push, full, pop, job_valid;
  job_t               front_job, back_job;
  logic [BCD_W-1:0]   front_bcd, back_bcd;
  logic [ENTRY_W-1:0] queue_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODE_FLAGS) ? 32'(mode_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MODE_FLAGS)) begin
      mode_q <= pwdata[MODE_W-1:0];
    end
  end

  tlnef_front #(
    .LINE_DIGITS (LINE_DIGITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .queue_full_i (full),
    .push_o       (push),
    .job_o        (front_job),
    .bcd_o        (front_bcd)
  );

  tlnef_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({front_bcd, front_job}),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .rdata_o (queue_rdata)
  );

  assign back_job = queue_rdata[JOB_W-1:0];
  assign back_bcd = queue_rdata[ENTRY_W-1:JOB_W];

  tlnef_back #(
    .LINE_DIGITS (LINE_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (back_job),
    .bcd_i       (back_bcd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

`ifndef SYNTHESIS
  // A job enters the queue only with an input transfer.
  a_push_needs_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (in_valid_i && in_ready_o))
    else $error("job pushed without input transfer");

  // Only a newline can be squeezed away; every other byte yields a job.
  a_non_lf_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_i.in_byte != CH_LF)) |-> push)
    else $error("non-newline byte produced no job");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full))
    else $error("job pushed into full queue");
`endif

endmodule

FILE: bench/text_line_number_escape_filter_top_tb.sv
`timescale 1ns / 1ps
module text_line_number_escape_filter_top_tb;
  import tlnef_pkg::*;

  localparam int DIGITS = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  text_line_number_escape_filter_top #(
    .LINE_DIGITS(DIGITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Stimulus and expectations.
  in_item_t  text_bytes_q[$];
  out_item_t expected_bytes_q[$];

  // Shadow of the filter state.
  logic [MODE_W-1:0]   mode_shadow = '0;
  logic [4*DIGITS-1:0] line_bcd = (4*DIGITS)'(1);
  logic                at_start = 1'b1;
  logic [1:0]          blank_cnt = '0;

  int  failures = 0;
  int  in_count = 0;
  int  out_count = 0;
  int  settings_cnt = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  no_idle = 1'b0;
  out_item_t want;

  // Works out the bytes the filter emits for one accepted input byte.
  task automatic predict_item(input in_item_t it);
    logic [7:0] c;
    logic [7:0] run[$];
    int top;
    bit carry;
    c = it.in_byte;
    if (it.start_of_file) begin
      line_bcd = (4*DIGITS)'(1);
      at_start = 1'b1;
      blank_cnt = '0;
    end
    if (c == CH_LF) begin
      if (at_start) begin
        if (blank_cnt < 2'd2) blank_cnt = blank_cnt + 2'd1;
        // A blank line following another blank line vanishes when squeezing.
        if (mode_shadow[MODE_SQUEEZE] && blank_cnt == 2'd2) return;
      end
    end
    if (at_start && (mode_shadow[MODE_NUM_ALL] ||
        (c != CH_LF && mode_shadow[MODE_NUM_NONBLANK]))) begin
      top = 0;
      for (int i = DIGITS - 1; i > 0; i--) begin
        if (top == 0 && line_bcd[4*i +: 4] != 4'd0) top = i;
      end
      for (int i = DIGITS - 1; i >= 0; i--) begin
        if (i > top) run.push_back(CH_SPACE);
        else run.push_back(8'(CH_ZERO + line_bcd[4*i +: 4]));
      end
      run.push_back(CH_TAB);
      if (line_bcd != {DIGITS{4'h9}}) begin
        carry = 1'b1;
        for (int i = 0; i < DIGITS; i++) begin
          if (carry) begin
            if (line_bcd[4*i +: 4] == 4'd9) begin
              line_bcd[4*i +: 4] = 4'd0;
            end else begin
              line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
              carry = 1'b0;
            end
          end
        end
      end
    end
    if (c == CH_LF) begin
      if (mode_shadow[MODE_SHOW_ENDS]) run.push_back(CH_DOLLAR);
      run.push_back(CH_LF);
      at_start = 1'b1;
    end else begin
      blank_cnt = '0;
      at_start = 1'b0;
      if ((c < CH_SPACE || c >= CH_DEL) &&
          (mode_shadow[MODE_NONPRINT] || (c == CH_TAB && mode_shadow[MODE_TABS]))) begin
        run.push_back(CH_CARET);
        if (c >= CH_HIGH) begin
          run.push_back(CH_LBRACK);
          run.push_back(8'(c - CH_HIGH));
        end else if (c == CH_DEL) begin
          run.push_back(CH_QUEST);
        end else begin
          run.push_back(8'(c + CH_AT));
        end
      end else begin
        run.push_back(c);
      end
    end
    foreach (run[i]) begin
      expected_bytes_q.push_back(out_item_t'{out_byte: run[i],
                                             last_of_run: (i == run.size() - 1)});
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic sof = 1'b0);
    text_bytes_q.push_back(in_item_t'{in_byte: b, start_of_file: sof});
  endtask

  // Mostly line-structured text with every kind of byte mixed in.
  task automatic queue_random_text(input int n);
    int made;
    int r;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        repeat ($urandom_range(1, 3)) begin
          queue_byte(CH_LF, $urandom_range(0, 29) == 0);
          made++;
        end
      end else begin
        if (r < 28) queue_byte(CH_TAB, $urandom_range(0, 29) == 0);
        else if (r < 38) queue_byte(8'($urandom_range(0, 31)), $urandom_range(0, 29) == 0);
        else if (r < 50) queue_byte(8'($urandom_range(128, 255)), $urandom_range(0, 29) == 0);
        else if (r < 53) queue_byte(CH_DEL, $urandom_range(0, 29) == 0);
        else queue_byte(8'($urandom_range(32, 126)), $urandom_range(0, 29) == 0);
        made++;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (text_bytes_q.size() != 0 || in_valid || expected_bytes_q.size() != 0);
    // A squeezed line yields nothing, so give the pipeline time to empty.
    repeat (10) @(posedge clk_i);
  endtask

  task automatic program_mode(input logic [MODE_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MODE_FLAGS, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    @(posedge clk_i);
    mode_shadow = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    if (prdata[MODE_W-1:0] !== value) begin
      $error("mode_flags: expected %02h, actual %02h", value, prdata[MODE_W-1:0]);
      failures++;
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_cnt++;
  endtask

  // Sender side.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (text_bytes_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 33)) begin
        in_valid <= 1'b1;
        in_item  <= text_bytes_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver side, with one long hold-off once the sender has a backlog.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && in_count >= 30 && text_bytes_q.size() >= 15) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= no_idle || ($urandom_range(0, 99) >= 33);
    end
  end

  // Checks every output transfer and predicts every input transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        out_count++;
        if (expected_bytes_q.size() == 0) begin
          $error("out_byte: expected none, actual %02h", out_item.out_byte);
          failures++;
        end else begin
          want = expected_bytes_q.pop_front();
          if (out_item.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", want.out_byte, out_item.out_byte);
            failures++;
          end
          if (out_item.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b",
                   want.last_of_run, out_item.last_of_run);
            failures++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_item(in_item);
        in_count++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Everything on: numbering, ends, carets, squeezing.
    program_mode(6'h3F);
    @(negedge clk_i);
    queue_byte(8'h41, 1'b1);
    queue_byte(CH_TAB);
    queue_byte(8'h00);
    queue_byte(8'h1F);
    queue_byte(CH_DEL);
    queue_byte(8'h80);
    queue_byte(8'hFF);
    queue_byte(8'h7E);
    queue_byte(CH_LF);
    queue_byte(CH_LF);
    queue_byte(CH_LF);
    queue_byte(CH_LF);
    queue_byte(8'h62);
    queue_byte(CH_LF);
    wait_drained();

    // Everything off: bytes pass through raw.
    program_mode(6'h00);
    @(negedge clk_i);
    queue_byte(CH_TAB);
    queue_byte(8'hFF);
    queue_byte(CH_LF);
    queue_byte(CH_LF);
    wait_drained();

    // Non-blank numbering only, then tabs with numbering of every line.
    program_mode(6'h01);
    @(negedge clk_i);
    queue_byte(CH_LF);
    queue_byte(8'h78);
    queue_byte(CH_LF);
    wait_drained();
    program_mode(6'h12);
    @(negedge clk_i);
    queue_byte(CH_TAB);
    queue_byte(CH_LF);
    wait_drained();

    // Both numbering bits with a restart of the file.
    program_mode(6'h03);
    @(negedge clk_i);
    queue_byte(8'h79, 1'b1);
    queue_byte(CH_LF);
    queue_byte(CH_LF);
    wait_drained();

    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) program_mode(6'h3F);
      else if (phase == 1) program_mode(6'h00);
      else program_mode(MODE_W'($urandom_range(0, 63)));
      no_idle = (phase == 2);
      @(negedge clk_i);
      queue_random_text(26);
      wait_drained();
    end
    no_idle = 1'b0;

    repeat (20) @(posedge clk_i);
    $display("Ran %0d input transfers and %0d output bytes under %0d mode settings,",
             in_count, out_count, settings_cnt);
    $display("including one long output hold-off and one stretch without idling.");
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
